>>> rtl/core/sglm_pkg.sv
// sglm_pkg: types and fixed constants of the sequence gap loss monitor
// no dependencies; imported by sequence_gap_loss_monitor
`default_nettype none

package sglm_pkg;

  // field widths fixed by the word format
  localparam int unsigned CHAN_W    = 2;
  localparam int unsigned ID_W      = 8;
  localparam int unsigned SEQ_W     = 8;
  localparam int unsigned PAIR_W    = 2 * ID_W;
  localparam int unsigned TOTAL_W   = 32;
  localparam int unsigned WLOST_W   = 16;
  localparam int unsigned PCT_W     = 15;

  // loss percentage scaling: percent times 256
  localparam int unsigned PCT_SCALE = 25600;

  // divider sizing: window_lost * 25600 fits 31 bits, sum fits 17 bits,
  // quotient never exceeds 25600 so 15 steps are enough
  localparam int unsigned PROD_W    = WLOST_W + PCT_W;
  localparam int unsigned DEN_W     = WLOST_W + 1;
  localparam int unsigned DIV_STEPS = PCT_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // request kinds
  localparam logic REQ_HEADER = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // one source table entry
  typedef struct packed {
    logic             seen;
    logic [SEQ_W-1:0] seq;
  } src_entry_t;

  // latched input word
  typedef struct packed {
    logic              req_type;
    logic [CHAN_W-1:0] channel;
    logic [ID_W-1:0]   source_system;
    logic [ID_W-1:0]   source_component;
    logic [SEQ_W-1:0]  sequence_number;
  } req_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_DIV,
    ST_PUSH
  } state_e;

endpackage

`default_nettype wire

>>> rtl/core/sequence_gap_loss_monitor.sv
// sequence_gap_loss_monitor: per-source sequence gap tracking and per-channel loss counts
// depends on sglm_pkg; source table is a 64k x 9 synchronous memory inside this module
//
//   channel | handshake                  | payload
//   --------+----------------------------+------------------------------------------------
//   in      | in_valid_i / in_stall_o    | req_type, channel, source_system,
//           |                            | source_component, sequence_number
//   out     | out_valid_o / out_stall_i  | report_valid, loss_percent_q8, total_lost,
//           |                            | total_received, lost_here
//
// a word without a report: table read at accept, update and result load in ST_LOOKUP, or in ST_PUSH while out stalls
// a word that closes a window passes through ST_DIV: the 15-step restoring divider sets the figure
// after reset the source table is cleared one entry a cycle, all 65536 entries, with in_stall_o high
// a new word is taken while the previous result still waits in the output register
`default_nettype none

module sequence_gap_loss_monitor
  import sglm_pkg::*;
#(
  parameter int unsigned CHANNELS      = 4,
  parameter int unsigned REPORT_PERIOD = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               req_type_i,
  input  wire logic [CHAN_W-1:0]  channel_i,
  input  wire logic [ID_W-1:0]    source_system_i,
  input  wire logic [ID_W-1:0]    source_component_i,
  input  wire logic [SEQ_W-1:0]   sequence_number_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    report_valid_o,
  output logic [PCT_W-1:0]        loss_percent_q8_o,
  output logic [TOTAL_W-1:0]      total_lost_o,
  output logic [TOTAL_W-1:0]      total_received_o,
  output logic [SEQ_W-1:0]        lost_here_o
);

  localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned WR_W  = $clog2(REPORT_PERIOD + 1);
  localparam int unsigned PAIRS = 2 ** PAIR_W;

  // state and control
  state_e               state_q, state_d;
  logic [PAIR_W-1:0]    clr_cnt_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic                 out_valid_q;
  req_t                 req_q;
  src_entry_t           rd_q;

  // per-channel counters
  logic [TOTAL_W-1:0] rt_q [CHANNELS];
  logic [TOTAL_W-1:0] lt_q [CHANNELS];
  logic [WR_W-1:0]    wr_q [CHANNELS];
  logic [WLOST_W-1:0] wl_q [CHANNELS];

  // staged result and divider
  logic               st_report_q;
  logic [TOTAL_W-1:0] st_lost_q;
  logic [TOTAL_W-1:0] st_recv_q;
  logic [SEQ_W-1:0]   st_here_q;
  logic [DEN_W-1:0]   den_q;
  logic [DEN_W-1:0]   rem_q;
  logic [PCT_W-1:0]   sh_q;
  logic [PCT_W-1:0]   quo_q;

  // output payload
  logic               out_report_q;
  logic [PCT_W-1:0]   out_pct_q;
  logic [TOTAL_W-1:0] out_lost_q;
  logic [TOTAL_W-1:0] out_recv_q;
  logic [SEQ_W-1:0]   out_here_q;

  // source table
  src_entry_t src_mem [PAIRS];

  logic               in_acc;
  logic               out_free;
  logic               mem_we;
  logic [PAIR_W-1:0]  mem_waddr;
  src_entry_t         mem_wdata;
  logic               load_direct;
  logic               load_push;

  logic               ch_ok;
  logic               is_msg;
  logic [CH_W-1:0]    ch_idx;
  logic [SEQ_W:0]     expected;
  logic [SEQ_W-1:0]   lost;
  logic [TOTAL_W-1:0] rt_new;
  logic [TOTAL_W-1:0] lt_new;
  logic [WR_W-1:0]    wr_new;
  logic [WLOST_W:0]   wl_sum;
  logic [WLOST_W-1:0] wl_new;
  logic               report_now;
  logic [PROD_W-1:0]  prod;
  logic [DEN_W:0]     rem_try;
  logic [DEN_W:0]     rem_sub;

  logic               stage_report;
  logic [TOTAL_W-1:0] stage_lost;
  logic [TOTAL_W-1:0] stage_recv;
  logic [SEQ_W-1:0]   stage_here;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // lookup datapath on the latched word and the table read
  always_comb begin
    ch_ok    = int'(req_q.channel) < CHANNELS;
    is_msg   = req_q.req_type == REQ_HEADER;
    ch_idx   = CH_W'(req_q.channel);
    expected = {1'b0, rd_q.seq} + 1'b1;
    lost     = '0;
    if (rd_q.seen && ({1'b0, req_q.sequence_number} > expected)) begin
      lost = req_q.sequence_number - expected[SEQ_W-1:0];
    end
    rt_new     = rt_q[ch_idx] + 1'b1;
    lt_new     = lt_q[ch_idx] + TOTAL_W'(lost);
    wr_new     = wr_q[ch_idx] + 1'b1;
    wl_sum     = {1'b0, wl_q[ch_idx]} + (WLOST_W + 1)'(lost);
    wl_new     = wl_sum[WLOST_W] ? '1 : wl_sum[WLOST_W-1:0];
    report_now = ch_ok && is_msg && (wr_new == WR_W'(REPORT_PERIOD));
    prod       = PROD_W'(wl_new) * PROD_W'(PCT_SCALE);
  end

  // result of this word before any division
  always_comb begin
    stage_report = 1'b0;
    stage_lost   = '0;
    stage_recv   = '0;
    stage_here   = '0;
    if (ch_ok && is_msg) begin
      stage_report = report_now;
      stage_lost   = lt_new;
      stage_recv   = rt_new;
      stage_here   = lost;
    end
  end

  // one restoring divider step
  always_comb begin
    rem_try = {rem_q, sh_q[PCT_W-1]};
    rem_sub = rem_try - {1'b0, den_q};
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (report_now) state_d = ST_DIV;
        else if (out_free) state_d = ST_IDLE;
        else state_d = ST_PUSH;
      end
      ST_DIV: begin
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o  = 1'b1;
    mem_we      = 1'b0;
    mem_waddr   = clr_cnt_q;
    mem_wdata   = '0;
    load_direct = 1'b0;
    load_push   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_LOOKUP: begin
        mem_we         = ch_ok && is_msg;
        mem_waddr      = {req_q.source_system, req_q.source_component};
        mem_wdata.seen = 1'b1;
        mem_wdata.seq  = req_q.sequence_number;
        load_direct    = !report_now && out_free;
      end
      ST_DIV: begin
      end
      ST_PUSH: begin
        load_push = out_free;
      end
      default: begin
      end
    endcase
  end

  // source table, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      src_mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_q <= src_mem[{source_system_i, source_component_i}];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (state_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end else begin
        div_cnt_q <= '0;
      end
      if (load_direct || load_push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // per-channel counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rt_q[i] <= '0;
        lt_q[i] <= '0;
        wr_q[i] <= '0;
        wl_q[i] <= '0;
      end
    end else if (state_q == ST_LOOKUP && ch_ok) begin
      if (!is_msg) begin
        rt_q[ch_idx] <= '0;
        lt_q[ch_idx] <= '0;
        wr_q[ch_idx] <= '0;
        wl_q[ch_idx] <= '0;
      end else begin
        rt_q[ch_idx] <= rt_new;
        lt_q[ch_idx] <= lt_new;
        wr_q[ch_idx] <= report_now ? '0 : wr_new;
        wl_q[ch_idx] <= report_now ? '0 : wl_new;
      end
    end
  end

  // input word latch
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q.req_type         <= req_type_i;
      req_q.channel          <= channel_i;
      req_q.source_system    <= source_system_i;
      req_q.source_component <= source_component_i;
      req_q.sequence_number  <= sequence_number_i;
    end
  end

  // staged result and divider
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOKUP) begin
      st_report_q <= stage_report;
      st_lost_q   <= stage_lost;
      st_recv_q   <= stage_recv;
      st_here_q   <= stage_here;
      den_q       <= DEN_W'(wr_new) + DEN_W'(wl_new);
      rem_q       <= DEN_W'(prod[PROD_W-1:PCT_W]);
      sh_q        <= prod[PCT_W-1:0];
      quo_q       <= '0;
    end else if (state_q == ST_DIV) begin
      sh_q <= {sh_q[PCT_W-2:0], 1'b0};
      if (!rem_sub[DEN_W]) begin
        rem_q <= rem_sub[DEN_W-1:0];
        quo_q <= {quo_q[PCT_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_try[DEN_W-1:0];
        quo_q <= {quo_q[PCT_W-2:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load_direct) begin
      out_report_q <= stage_report;
      out_pct_q    <= '0;
      out_lost_q   <= stage_lost;
      out_recv_q   <= stage_recv;
      out_here_q   <= stage_here;
    end else if (load_push) begin
      out_report_q <= st_report_q;
      out_pct_q    <= quo_q;
      out_lost_q   <= st_lost_q;
      out_recv_q   <= st_recv_q;
      out_here_q   <= st_here_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign report_valid_o    = out_report_q;
  assign loss_percent_q8_o = out_pct_q;
  assign total_lost_o      = out_lost_q;
  assign total_received_o  = out_recv_q;
  assign lost_here_o       = out_here_q;

endmodule

`default_nettype wire
